@@ rtl/rsfl_pkg.sv @@
// ----------------------------------------------------------------------------
// rsfl_pkg
// Shared types and constants of the record store with a LIFO free list.
// ----------------------------------------------------------------------------
package rsfl_pkg;

  localparam int SLOTS     = 64;
  localparam int DATA_BITS = 64;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_LIST   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_DATA = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]           command;
    logic [SLOT_W-1:0]    slot;
    logic [DATA_BITS-1:0] payload;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]    slot_out;
    logic [DATA_BITS-1:0] data_out;
    logic [1:0]           status;
    logic                 last;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic walk;
  } ctrl_t;

  typedef struct packed {
    logic list_empty;
    logic walk_end;
  } stat_t;

endpackage

@@ rtl/rsfl_ctrl.sv @@
// ----------------------------------------------------------------------------
// rsfl_ctrl
// Controller: accepts a word, then runs the execute state or a slot walk.
// ----------------------------------------------------------------------------
module rsfl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     command,
  input  rsfl_pkg::stat_t stat,
  output logic           busy,
  output rsfl_pkg::ctrl_t ctrl
);
  import rsfl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LIST = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next   = state;
    ctrl.capture = 1'b0;
    ctrl.exec    = 1'b0;
    ctrl.walk    = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.capture = 1'b1;
          if (command == CMD_LIST && !stat.list_empty) begin
            state_next = S_LIST;
          end else begin
            state_next = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        ctrl.exec  = 1'b1;
        state_next = S_IDLE;
      end
      S_LIST: begin
        ctrl.walk = 1'b1;
        if (stat.walk_end) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

@@ rtl/rsfl_dpath.sv @@
// ----------------------------------------------------------------------------
// rsfl_dpath
// Datapath: record and link memories, live bits, free list head and counts,
// list walk pipeline and result register.
// ----------------------------------------------------------------------------
module rsfl_dpath (
  input  logic            clk,
  input  logic            rst,
  input  rsfl_pkg::req_t  req,
  input  rsfl_pkg::ctrl_t ctrl,
  output rsfl_pkg::stat_t stat,
  output logic            result_valid,
  output rsfl_pkg::rsp_t  result
);
  import rsfl_pkg::*;

  logic [DATA_BITS-1:0] record_mem [SLOTS];
  logic [SLOT_W-1:0]    next_free  [SLOTS];
  logic [SLOTS-1:0]     live_bits;

  logic [SLOT_W-1:0]    free_head;
  logic                 free_nonempty;
  logic [CNT_W-1:0]     used_count;
  logic [CNT_W-1:0]     live_count;

  req_t                 req_q;
  logic [DATA_BITS-1:0] rec_q;
  logic [SLOT_W-1:0]    link_q;

  logic [SLOT_W-1:0]    idx;
  logic [SLOT_W-1:0]    idx_q;
  logic                 hit_q;
  logic [CNT_W-1:0]     emit_cnt;

  logic [SLOT_W-1:0]    rec_addr;
  logic                 rec_we;
  logic [SLOT_W-1:0]    add_slot;
  logic                 link_we;
  logic [SLOT_W-1:0]    link_wdata;
  logic                 ok;

  logic [SLOT_W-1:0]    free_head_next;
  logic                 free_nonempty_next;
  logic [CNT_W-1:0]     used_count_next;
  logic [CNT_W-1:0]     live_count_next;
  logic                 live_set;
  logic                 live_clr;
  rsp_t                 exec_rsp;

  assign rec_addr        = ctrl.walk ? idx : req.slot;
  assign ok              = live_bits[req_q.slot];
  assign stat.list_empty = (live_count == '0);
  assign stat.walk_end   = (idx == SLOT_W'(SLOTS - 1));

  always_comb begin
    free_head_next     = free_head;
    free_nonempty_next = free_nonempty;
    used_count_next    = used_count;
    live_count_next    = live_count;
    rec_we             = 1'b0;
    add_slot           = used_count[SLOT_W-1:0];
    link_we            = 1'b0;
    link_wdata         = free_nonempty ? free_head : req_q.slot;
    live_set           = 1'b0;
    live_clr           = 1'b0;
    exec_rsp.slot_out  = req_q.slot;
    exec_rsp.data_out  = '0;
    exec_rsp.status    = ST_OK;
    exec_rsp.last      = 1'b1;
    case (req_q.command)
      CMD_ADD: begin
        if (free_nonempty) begin
          add_slot = free_head;
          if (link_q == free_head) begin
            free_nonempty_next = 1'b0;
          end else begin
            free_head_next = link_q;
          end
          rec_we = 1'b1;
        end else if (used_count < CNT_W'(SLOTS)) begin
          used_count_next = used_count + 1'b1;
          rec_we          = 1'b1;
        end
        if (rec_we) begin
          live_set          = 1'b1;
          live_count_next   = live_count + 1'b1;
          exec_rsp.slot_out = add_slot;
        end else begin
          exec_rsp.slot_out = '0;
          exec_rsp.status   = ST_FULL;
        end
      end
      CMD_READ: begin
        if (ok) begin
          exec_rsp.data_out = rec_q;
        end else begin
          exec_rsp.status = ST_NO_DATA;
        end
      end
      CMD_DELETE: begin
        if (ok) begin
          link_we            = 1'b1;
          live_clr           = 1'b1;
          free_head_next     = req_q.slot;
          free_nonempty_next = 1'b1;
          live_count_next    = live_count - 1'b1;
        end else begin
          exec_rsp.status = ST_NO_DATA;
        end
      end
      CMD_LIST: begin
        exec_rsp.slot_out = '0;
        exec_rsp.status   = ST_NO_DATA;
      end
      default: exec_rsp.status = ST_NO_DATA;
    endcase
  end

  always_ff @(posedge clk) begin
    rec_q <= record_mem[rec_addr];
    if (ctrl.exec && rec_we) begin
      record_mem[add_slot] <= req_q.payload;
    end
  end

  always_ff @(posedge clk) begin
    link_q <= next_free[free_head];
    if (ctrl.exec && link_we) begin
      next_free[req_q.slot] <= link_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      req_q <= req;
    end
    idx_q <= idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_bits     <= '0;
      free_head     <= '0;
      free_nonempty <= 1'b0;
      used_count    <= '0;
      live_count    <= '0;
      idx           <= '0;
      hit_q         <= 1'b0;
      emit_cnt      <= '0;
      result_valid  <= 1'b0;
    end else begin
      hit_q        <= ctrl.walk && live_bits[idx];
      result_valid <= ctrl.exec || hit_q;
      if (ctrl.capture) begin
        idx <= '0;
      end else if (ctrl.walk) begin
        idx <= idx + 1'b1;
      end
      if (ctrl.capture) begin
        emit_cnt <= '0;
      end else if (hit_q) begin
        emit_cnt <= emit_cnt + 1'b1;
      end
      if (ctrl.exec) begin
        free_head     <= free_head_next;
        free_nonempty <= free_nonempty_next;
        used_count    <= used_count_next;
        live_count    <= live_count_next;
        if (live_set) begin
          live_bits[add_slot] <= 1'b1;
        end
        if (live_clr) begin
          live_bits[req_q.slot] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit_q) begin
      result.slot_out <= idx_q;
      result.data_out <= rec_q;
      result.status   <= ST_OK;
      result.last     <= ((emit_cnt + 1'b1) == live_count);
    end else if (ctrl.exec) begin
      result <= exec_rsp;
    end
  end

endmodule

@@ rtl/record_store_free_list_core.sv @@
// ----------------------------------------------------------------------------
// record_store_free_list_core
// Fixed-slot record store with a LIFO free list of deleted slots.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  command   start / busy            req    (command, slot, payload)
//  result    result_valid strobe     result (slot_out, data_out, status, last)
//
//  Add, read and delete accept the word, then do one memory read-modify-write.
//  List walks every slot, one slot per cycle through the record memory read port;
//  hits pass hit_q and rec_q to the result register. Empty list answers NO_DATA.
//  Reset clears live bits, free list head and counts at once; no sweep.
//  Each result word stands for one cycle; the receiver cannot stall it.
module record_store_free_list_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  rsfl_pkg::req_t req,
  output logic           result_valid,
  output rsfl_pkg::rsp_t result
);
  import rsfl_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  rsfl_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (req.command),
    .stat    (stat),
    .busy    (busy),
    .ctrl    (ctrl)
  );

  rsfl_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .ctrl         (ctrl),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

@@ tb/tb_record_store_free_list_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_record_store_free_list_core
// Self-checking bench for the record store with a LIFO free list. A short
// directed plan covers the empty store, missing slots, free list reuse down
// to its self-linked end and the list walk. Random traffic then fills the
// store to full and drains it again, with idle bursts on the command side.
// Every result word is checked against the plan's expected word or a local
// model of slots, live bits and the free list chain.
// ----------------------------------------------------------------------------
module tb_record_store_free_list_core;
  import rsfl_pkg::*;

  localparam int RANDOM_WORDS = 400;
  localparam int QUIET_WORDS  = 60;
  localparam int TAIL_CYCLES  = 2 * SLOTS + 8;

  localparam logic [DATA_BITS-1:0] ALL_ONES = '1;
  localparam logic [DATA_BITS-1:0] PAT_A    = 64'hA5A5_5A5A_0F0F_F0F0;
  localparam logic [DATA_BITS-1:0] PAT_B    = 64'h8000_0000_0000_0000;
  localparam logic [DATA_BITS-1:0] PAT_C    = 64'hDEAD_BEEF_CAFE_F00D;

  typedef struct packed {
    req_t word;
    logic typed;
    rsp_t want;
  } plan_row_t;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  logic result_valid;
  rsp_t result;

  // store model
  logic [DATA_BITS-1:0] rec_data  [SLOTS];
  bit                   rec_live  [SLOTS];
  logic [SLOT_W-1:0]    free_link [SLOTS];
  logic [SLOT_W-1:0]    free_top;
  bit                   free_any;
  int unsigned          append_ptr;
  int unsigned          live_total;

  rsp_t        pending_results [$];
  rsp_t        due;
  int unsigned err_count = 0;

  plan_row_t plan [21] = '{
    {CMD_LIST,   6'd0,  64'd0,    1'b1, 6'd0,  64'd0,    ST_NO_DATA, 1'b1},
    {CMD_READ,   6'd0,  64'd0,    1'b1, 6'd0,  64'd0,    ST_NO_DATA, 1'b1},
    {CMD_DELETE, 6'd63, ALL_ONES, 1'b1, 6'd63, 64'd0,    ST_NO_DATA, 1'b1},
    {CMD_ADD,    6'd63, ALL_ONES, 1'b1, 6'd0,  64'd0,    ST_OK,      1'b1},
    {CMD_ADD,    6'd0,  64'd0,    1'b1, 6'd1,  64'd0,    ST_OK,      1'b1},
    {CMD_ADD,    6'd21, PAT_A,    1'b1, 6'd2,  64'd0,    ST_OK,      1'b1},
    {CMD_READ,   6'd0,  64'd0,    1'b1, 6'd0,  ALL_ONES, ST_OK,      1'b1},
    {CMD_READ,   6'd1,  ALL_ONES, 1'b1, 6'd1,  64'd0,    ST_OK,      1'b1},
    {CMD_READ,   6'd2,  64'd0,    1'b1, 6'd2,  PAT_A,    ST_OK,      1'b1},
    {CMD_DELETE, 6'd1,  64'd0,    1'b1, 6'd1,  64'd0,    ST_OK,      1'b1},
    {CMD_DELETE, 6'd1,  64'd0,    1'b1, 6'd1,  64'd0,    ST_NO_DATA, 1'b1},
    {CMD_READ,   6'd1,  64'd0,    1'b1, 6'd1,  64'd0,    ST_NO_DATA, 1'b1},
    {CMD_DELETE, 6'd0,  ALL_ONES, 1'b1, 6'd0,  64'd0,    ST_OK,      1'b1},
    {CMD_LIST,   6'd63, ALL_ONES, 1'b1, 6'd2,  PAT_A,    ST_OK,      1'b1},
    {CMD_ADD,    6'd42, 64'd1,    1'b1, 6'd0,  64'd0,    ST_OK,      1'b1},
    {CMD_ADD,    6'd0,  PAT_B,    1'b1, 6'd1,  64'd0,    ST_OK,      1'b1},
    {CMD_ADD,    6'd0,  PAT_C,    1'b1, 6'd3,  64'd0,    ST_OK,      1'b1},
    {CMD_LIST,   6'd0,  64'd0,    1'b0, 6'd0,  64'd0,    ST_OK,      1'b0},
    {CMD_DELETE, 6'd2,  64'd0,    1'b0, 6'd0,  64'd0,    ST_OK,      1'b0},
    {CMD_READ,   6'd63, 64'd0,    1'b1, 6'd63, 64'd0,    ST_NO_DATA, 1'b1},
    {CMD_READ,   6'd3,  64'd0,    1'b0, 6'd0,  64'd0,    ST_OK,      1'b0}
  };

  record_store_free_list_core u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void enqueue_result(input rsp_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  task automatic store_step(input req_t w, input bit emit);
    rsp_t        r;
    int unsigned s;
    int unsigned hits;
    int          t;
    s          = 32'(w.slot);
    r.slot_out = w.slot;
    r.data_out = '0;
    r.status   = ST_OK;
    r.last     = 1'b1;
    case (w.command)
      CMD_ADD: begin
        r.slot_out = '0;
        if (free_any) begin
          s = 32'(free_top);
          if (free_link[s] == free_top) free_any = 1'b0;
          else free_top = free_link[s];
        end else if (append_ptr < SLOTS) begin
          s = append_ptr;
          append_ptr++;
        end else begin
          r.status = ST_FULL;
        end
        if (r.status == ST_OK) begin
          rec_data[s] = w.payload;
          rec_live[s] = 1'b1;
          live_total++;
          r.slot_out = SLOT_W'(s);
        end
      end
      CMD_READ: begin
        if (rec_live[s]) r.data_out = rec_data[s];
        else r.status = ST_NO_DATA;
      end
      CMD_DELETE: begin
        if (rec_live[s]) begin
          free_link[s] = free_any ? free_top : w.slot;
          free_top     = w.slot;
          free_any     = 1'b1;
          rec_live[s]  = 1'b0;
          live_total--;
        end else begin
          r.status = ST_NO_DATA;
        end
      end
      default: begin
        hits       = 0;
        r.slot_out = '0;
        r.status   = ST_NO_DATA;
        for (t = 0; t < SLOTS; t++) begin
          if (rec_live[t]) begin
            if (hits != 0 && emit) begin
              r.last = 1'b0;
              enqueue_result(r);
            end
            r.slot_out = SLOT_W'(t);
            r.data_out = rec_data[t];
            r.status   = ST_OK;
            r.last     = 1'b1;
            hits++;
          end
        end
      end
    endcase
    if (emit) enqueue_result(r);
  endtask

  function automatic logic [SLOT_W-1:0] pick_live();
    int unsigned k;
    if (live_total == 0) return SLOT_W'($urandom);
    k = $urandom_range(0, live_total - 1);
    for (int t = 0; t < SLOTS; t++) begin
      if (rec_live[t]) begin
        if (k == 0) return SLOT_W'(t);
        k--;
      end
    end
    return '0;
  endfunction

  function automatic req_t next_command(input bit shrink);
    req_t        w;
    int unsigned roll;
    w.command = CMD_LIST;
    w.slot    = SLOT_W'($urandom);
    case ($urandom_range(0, 15))
      0:       w.payload = '0;
      1:       w.payload = '1;
      default: w.payload = {$urandom, $urandom};
    endcase
    roll = $urandom_range(0, 99);
    if (!shrink) begin
      if (roll < 60) w.command = CMD_ADD;
      else if (roll < 75) begin
        w.command = CMD_READ;
        w.slot    = pick_live();
      end else if (roll < 85) begin
        w.command = CMD_DELETE;
        w.slot    = pick_live();
      end else if (roll < 95) w.command = $urandom_range(0, 1) ? CMD_READ : CMD_DELETE;
    end else begin
      if (roll < 50) begin
        w.command = CMD_DELETE;
        w.slot    = pick_live();
      end else if (roll < 60) w.command = CMD_DELETE;
      else if (roll < 80) w.command = CMD_ADD;
      else if (roll < 95) begin
        w.command = CMD_READ;
        w.slot    = pick_live();
      end
    end
    return w;
  endfunction

  function automatic int unsigned pick_gap(input bit quiet);
    if (quiet || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 12);
  endfunction

  task automatic send_word(input req_t w, input bit typed, input rsp_t want,
                           input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= w;
    do @(posedge clk); while (busy);
    store_step(w, !typed);
    if (typed) enqueue_result(want);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: slot_out %0d status %0d last %0b",
               result.slot_out, result.status, result.last);
        err_count++;
      end else begin
        due = pending_results.pop_front();
        if (result.slot_out !== due.slot_out) begin
          $error("slot_out: expected %0d, got %0d", due.slot_out, result.slot_out);
          err_count++;
        end
        if (result.data_out !== due.data_out) begin
          $error("data_out: expected %h, got %h", due.data_out, result.data_out);
          err_count++;
        end
        if (result.status !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, result.status);
          err_count++;
        end
        if (result.last !== due.last) begin
          $error("last: expected %0b, got %0b", due.last, result.last);
          err_count++;
        end
      end
    end
  end

  initial begin
    req_t        w;
    bit          shrink;
    int unsigned fulls;
    for (int t = 0; t < SLOTS; t++) rec_live[t] = 1'b0;
    free_top   = '0;
    free_any   = 1'b0;
    append_ptr = 0;
    live_total = 0;
    shrink     = 1'b0;
    fulls      = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (plan[i]) send_word(plan[i].word, plan[i].typed, plan[i].want, pick_gap(1'b0));
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      w = next_command(shrink);
      if (w.command == CMD_ADD && live_total == SLOTS) fulls++;
      send_word(w, 1'b0, '0, pick_gap(n >= RANDOM_WORDS - QUIET_WORDS));
      if (!shrink && fulls >= 3) begin
        shrink = 1'b1;
        fulls  = 0;
      end else if (shrink && live_total <= 2) begin
        shrink = 1'b0;
      end
      // hold the command side until the store has answered everything
      if (n == RANDOM_WORDS / 2) drain_results();
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("** record_store_free_list_core: PASSED **");
    end else begin
      $display("** record_store_free_list_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("** record_store_free_list_core: FAILED **");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rsfl_pkg.sv
rtl/rsfl_ctrl.sv
rtl/rsfl_dpath.sv
rtl/record_store_free_list_core.sv
tb/tb_record_store_free_list_core.sv
